[sv/scp_pkg.sv]
`default_nettype none

package scp_pkg;

    localparam logic [7:0] CMD_HELP   = 8'h68;
    localparam logic [7:0] CMD_INFO   = 8'h70;
    localparam logic [7:0] CMD_ANGLE  = 8'h64;
    localparam logic [7:0] CMD_LATCH  = 8'h44;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_MAX  = 8'd9;

    localparam logic [7:0] MAX_ANGLE_RESET = 8'd180;

    localparam logic [0:0] REG_MAX_ANGLE = 1'b0;

    localparam int unsigned DIGITS = 3;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_HELP      = 4'd1,
        EV_INFO      = 4'd2,
        EV_UNKNOWN   = 4'd3,
        EV_TOO_FEW   = 4'd4,
        EV_NO_LATCH  = 4'd5,
        EV_BAD_DIGIT = 4'd6,
        EV_RANGE     = 4'd7,
        EV_SET       = 4'd8
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [9:0]  received_angle;
        logic [7:0]  current_angle;
    } result_t;

endpackage

`default_nettype wire

[sv/scp_in_stage.sv]
`default_nettype none

module scp_in_stage
    import scp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // a held item leaves in the same cycle a new one comes in
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

[sv/scp_parser.sv]
`default_nettype none

module scp_parser
    import scp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    input  wire logic [7:0] max_angle,
    output result_t         result
);

    logic       collecting_reg;
    logic       collecting_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [7:0] stored_reg;
    logic [7:0] stored_next;
    logic [7:0] digit_reg [DIGITS];
    logic       digit_we;

    logic [7:0] off0;
    logic [7:0] off1;
    logic [7:0] off2;
    logic       all_digits;
    logic [9:0] angle;
    logic [1:0] digit_idx;

    assign off0 = digit_reg[0] - ASCII_ZERO;
    assign off1 = digit_reg[1] - ASCII_ZERO;
    assign off2 = digit_reg[2] - ASCII_ZERO;
    assign all_digits = (off0 <= DIGIT_MAX) && (off1 <= DIGIT_MAX) && (off2 <= DIGIT_MAX);

    assign angle = (10'(off0[3:0]) * 10'd100) + (10'(off1[3:0]) * 10'd10) + 10'(off2[3:0]);

    assign digit_idx = 2'(count_reg - 3'd1);

    always_comb begin
        collecting_next       = collecting_reg;
        count_next            = count_reg;
        stored_next           = stored_reg;
        digit_we              = 1'b0;
        result.event_res      = EV_NONE;
        result.received_angle = '0;
        if (!collecting_reg) begin
            case (rx_byte)
                CMD_HELP:  result.event_res = EV_HELP;
                CMD_INFO:  result.event_res = EV_INFO;
                CMD_ANGLE: begin
                    collecting_next = 1'b1;
                    count_next      = 3'd1;
                end
                default:   result.event_res = EV_UNKNOWN;
            endcase
        end else begin
            case (count_reg) inside
                [3'd1:3'd3]: begin
                    if (rx_byte == CMD_LATCH) begin
                        result.event_res = EV_TOO_FEW;
                        collecting_next  = 1'b0;
                        count_next       = '0;
                    end else begin
                        digit_we   = 1'b1;
                        count_next = count_reg + 3'd1;
                    end
                end
                3'd4: begin
                    collecting_next = 1'b0;
                    count_next      = '0;
                    if (rx_byte != CMD_LATCH) begin
                        result.event_res = EV_NO_LATCH;
                    end else if (!all_digits) begin
                        result.event_res = EV_BAD_DIGIT;
                    end else begin
                        result.received_angle = angle;
                        if (angle > {2'b00, max_angle}) begin
                            result.event_res = EV_RANGE;
                        end else begin
                            result.event_res = EV_SET;
                            stored_next      = angle[7:0];
                        end
                    end
                end
                default: begin
                    // count out of step with collecting
                    result.event_res = EV_BAD_DIGIT;
                    collecting_next  = 1'b0;
                    count_next       = '0;
                end
            endcase
        end
        result.current_angle = stored_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            stored_reg     <= '0;
        end else if (step) begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            stored_reg     <= stored_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && digit_we) begin
            digit_reg[digit_idx] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

[sv/scp_out_stage.sv]
`default_nettype none

module scp_out_stage
    import scp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load_valid,
    input  wire result_t load_data,
    output logic         load_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign load_ready = !valid_reg || m_ready;
    assign valid_next = (load_valid && load_ready) || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

[sv/servo_angle_command_parser_top.sv]
`default_nettype none

// Servo angle command parser. Takes one received command byte per item and
// returns exactly one result item per byte: an event code, the decoded angle
// (nonzero only with the out-of-range and angle-set events) and the stored
// servo angle after that byte. Idle bytes 'h' and 'p' report help and info,
// 'd' opens an angle command of three ASCII digits closed by 'D'; anything
// else reports unknown. Each byte is registered at the input, decoded
// combinationally against the parser state and registered at the output,
// so a byte can be taken every clock cycle while the output is not stalled.
// The max_angle register (reset 180) sits at APB address 0 and should be
// written only while no byte is in flight.

module servo_angle_command_parser_top
    import scp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_res,
    output logic [9:0]       m_received_angle,
    output logic [7:0]       m_current_angle
);

    logic [7:0] max_angle_reg;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       load_ready;
    logic       step;
    result_t    result;
    result_t    m_data;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_angle_reg <= MAX_ANGLE_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_MAX_ANGLE)) begin
            max_angle_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr == REG_MAX_ANGLE) ? {24'd0, max_angle_reg} : 32'd0;

    assign step = byte_valid && load_ready;

    scp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (load_ready),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    scp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (byte_data),
        .max_angle (max_angle_reg),
        .result    (result)
    );

    scp_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (byte_valid),
        .load_data  (result),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    assign m_event_res      = m_data.event_res;
    assign m_received_angle = m_data.received_angle;
    assign m_current_angle  = m_data.current_angle;

endmodule

`default_nettype wire
